[rtl/gbs_pkg.sv]
// Package with the item types, register codes, state encoding and helpers of the box suppressor.
package gbs_pkg;

	// Default capacity of one detection set.
	localparam int MAX_BOXES_DEF = 64;

	// Fixed field widths.
	localparam int EDGE_W  = 16;
	localparam int SCORE_W = 16;
	localparam int CLS_W   = 7;
	localparam int IDX_W   = 6;
	localparam int KEEP_W  = 7;
	localparam int AREA_W  = 2 * EDGE_W;
	localparam int UNI_W   = AREA_W + 1;
	localparam int PROD_W  = UNI_W + 16;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_IOU_LIMIT   = 2'd0;
	localparam logic [1:0] REG_SCORE_FLOOR = 2'd1;
	localparam logic [1:0] REG_KEEP_LIMIT  = 2'd2;

	// Register reset values.
	localparam logic [15:0]       IOU_LIMIT_RST   = 16'd29491;
	localparam logic [15:0]       SCORE_FLOOR_RST = 16'd16384;
	localparam logic [KEEP_W-1:0] KEEP_LIMIT_RST  = 7'd64;

	// One input item.
	typedef struct packed {
		logic [EDGE_W-1:0]  box_left;
		logic [EDGE_W-1:0]  box_top;
		logic [EDGE_W-1:0]  box_right;
		logic [EDGE_W-1:0]  box_bottom;
		logic [SCORE_W-1:0] score;
		logic [CLS_W-1:0]   class_id;
		logic               last_box;
	} det_item_t;

	// One result item.
	typedef struct packed {
		logic [IDX_W-1:0] kept_index;
		logic             kept_valid;
		logic             overflow;
		logic             last_result;
	} res_item_t;

	// Corner box as held in the store.
	typedef struct packed {
		logic [EDGE_W-1:0] bottom;
		logic [EDGE_W-1:0] right;
		logic [EDGE_W-1:0] top;
		logic [EDGE_W-1:0] left;
	} box_t;

	// One stored detection.
	typedef struct packed {
		box_t               box;
		logic [SCORE_W-1:0] score;
		logic [CLS_W-1:0]   cls;
		logic [IDX_W-1:0]   pos;
	} entry_t;

	// Outcome of one entry of a scan pass.
	typedef struct packed {
		logic               v;
		logic [IDX_W-1:0]   idx;
		logic [SCORE_W-1:0] score;
		logic               sup;
	} scan_res_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EMIT_MID,
		S_PICK_RD,
		S_PICK_CAP,
		S_AREA,
		S_EMIT_END
	} state_t;

	// Extent of an edge pair, zero when inverted.
	function automatic logic [EDGE_W-1:0] span(input logic [EDGE_W-1:0] lo,
		input logic [EDGE_W-1:0] hi);
		span = (hi > lo) ? (hi - lo) : '0;
	endfunction

endpackage

[rtl/gbs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/gbs_overlap.sv]
// Pipelined overlap test of stored entries against the current pick.
module gbs_overlap
	import gbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              have_pick,
	input  box_t              pick_box,
	input  logic [CLS_W-1:0]  pick_cls,
	input  logic [AREA_W-1:0] pick_area,
	input  logic [15:0]       iou_limit,
	input  logic              in_v,
	input  logic [IDX_W-1:0]  in_idx,
	input  entry_t            in_ent,
	output logic              busy,
	output scan_res_t         res
);

	logic               v_s2, v_s3, v_s4, v_s5;
	logic [IDX_W-1:0]   idx_s2, idx_s3, idx_s4, idx_s5;
	logic [SCORE_W-1:0] sc_s2, sc_s3, sc_s4, sc_s5;
	logic               same_s2, same_s3, same_s4, same_s5;
	logic [EDGE_W-1:0]  iw_s2, ih_s2, bw_s2, bh_s2;
	logic [AREA_W-1:0]  inter_s3, areab_s3, inter_s4, inter_s5;
	logic [UNI_W-1:0]   uni_s4;
	logic [PROD_W-1:0]  prod_s5;
	logic [EDGE_W-1:0]  il, it, ir, ib;

	// Intersection corners.
	always_comb begin
		il = (in_ent.box.left > pick_box.left) ? in_ent.box.left : pick_box.left;
		it = (in_ent.box.top > pick_box.top) ? in_ent.box.top : pick_box.top;
		ir = (in_ent.box.right < pick_box.right) ? in_ent.box.right : pick_box.right;
		ib = (in_ent.box.bottom < pick_box.bottom) ? in_ent.box.bottom : pick_box.bottom;
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= in_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Spans, then areas, then union, then the scaled limit.
	always_ff @(posedge clk) begin
		idx_s2   <= in_idx;
		sc_s2    <= in_ent.score;
		same_s2  <= have_pick && (in_ent.cls == pick_cls);
		iw_s2    <= span(il, ir);
		ih_s2    <= span(it, ib);
		bw_s2    <= span(in_ent.box.left, in_ent.box.right);
		bh_s2    <= span(in_ent.box.top, in_ent.box.bottom);

		idx_s3   <= idx_s2;
		sc_s3    <= sc_s2;
		same_s3  <= same_s2;
		inter_s3 <= iw_s2 * ih_s2;
		areab_s3 <= bw_s2 * bh_s2;

		idx_s4   <= idx_s3;
		sc_s4    <= sc_s3;
		same_s4  <= same_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= UNI_W'(pick_area) + UNI_W'(areab_s3) - UNI_W'(inter_s3);

		idx_s5   <= idx_s4;
		sc_s5    <= sc_s4;
		same_s5  <= same_s4;
		inter_s5 <= inter_s4;
		prod_s5  <= PROD_W'(iou_limit) * PROD_W'(uni_s4);
	end

	// Final compare.
	always_comb begin
		res.v     = v_s5;
		res.idx   = idx_s5;
		res.score = sc_s5;
		res.sup   = same_s5 && ({1'b0, inter_s5, 16'b0} > prod_s5);
		busy      = v_s2 | v_s3 | v_s4 | v_s5;
	end

endmodule

[rtl/greedy_box_suppression.sv]
// Top level of the greedy box suppressor: loading, scan sequencing and result output.
//
// Channel   Direction  Handshake          Payload
// det       in         det_valid/stall    det_item_t, one detection
// res       out        res_valid/stall    res_item_t, one kept index
// apb       in         psel/penable       iou_limit, score_floor, keep_limit
//
// Loading takes one item per cycle while idle. After the last item of a set, each
// kept detection costs one scan of the n stored entries through the store's read
// port, then a drain of the overlap pipeline and the pick handling; a scan that
// finds no candidate, or reaching the keep limit, ends the set. Reset clears the
// control state and registers; the store needs no clearing. A stalled result
// holds the output register and the emit states; input stalls until the set ends.
module greedy_box_suppression
	import gbs_pkg::*;
#(
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               det_valid,
	output logic               det_stall,
	input  det_item_t          det,
	output logic               res_valid,
	input  logic               res_stall,
	output res_item_t          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	state_t state_q, state_d;

	logic [15:0]        iou_q, floor_q;
	logic [KEEP_W-1:0]  keep_q, lim_eff;
	logic [CW-1:0]      stored_q, load_q, scan_q;
	logic               ovf_q, have_pick_q;
	logic [MAX_BOXES-1:0] done_q;
	logic               best_v_q;
	logic [AW-1:0]      best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	box_t               pick_box_q;
	logic [CLS_W-1:0]   pick_cls_q;
	logic [EDGE_W-1:0]  pick_w_q, pick_h_q;
	logic [AREA_W-1:0]  pick_area_q;
	logic               pend_v_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic [KEEP_W-1:0]  emit_cnt_q;
	logic               out_v_q;
	res_item_t          res_q;
	logic               v_s1;
	logic [AW-1:0]      idx_s1;

	logic               acc, store, scan_end, out_free, pipe_busy, ram_we, out_load;
	logic [CW-1:0]      n_next;
	logic [AW-1:0]      raddr;
	res_item_t          out_data;
	entry_t             wr_ent, rd_ent;
	scan_res_t          sres;
	logic               ov_busy;

	// Effective result cap.
	always_comb begin
		if (keep_q == '0) begin
			lim_eff = KEEP_W'(1);
		end else if (keep_q > KEEP_W'(MAX_BOXES)) begin
			lim_eff = KEEP_W'(MAX_BOXES);
		end else begin
			lim_eff = keep_q;
		end
	end

	// Load decode and shared conditions.
	always_comb begin
		acc       = det_valid && !det_stall;
		store     = (load_q < CW'(MAX_BOXES)) && (det.score > floor_q);
		n_next    = stored_q + CW'(store);
		scan_end  = (scan_q == stored_q - CW'(1));
		out_free  = !out_v_q || !res_stall;
		pipe_busy = v_s1 | ov_busy;
		wr_ent.box.left   = det.box_left;
		wr_ent.box.top    = det.box_top;
		wr_ent.box.right  = det.box_right;
		wr_ent.box.bottom = det.box_bottom;
		wr_ent.score      = det.score;
		wr_ent.cls        = det.class_id;
		wr_ent.pos        = IDX_W'(load_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && det.last_box) begin
					state_d = (n_next == '0) ? S_EMIT_END : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!pipe_busy) begin
					if (!best_v_q) begin
						state_d = S_EMIT_END;
					end else if (pend_v_q) begin
						state_d = S_EMIT_MID;
					end else begin
						state_d = S_PICK_RD;
					end
				end
			end
			S_EMIT_MID: begin
				if (out_free) begin
					state_d = S_PICK_RD;
				end
			end
			S_PICK_RD: state_d = S_PICK_CAP;
			S_PICK_CAP: begin
				state_d = (emit_cnt_q + KEEP_W'(1) >= lim_eff) ? S_EMIT_END : S_AREA;
			end
			S_AREA: state_d = S_SCAN;
			S_EMIT_END: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		det_stall = (state_q != S_IDLE);
		ram_we    = 1'b0;
		out_load  = 1'b0;
		raddr     = scan_q[AW-1:0];
		out_data  = res_q;
		unique case (state_q)
			S_IDLE: ram_we = acc && store;
			S_PICK_RD: raddr = best_idx_q;
			S_EMIT_MID: begin
				out_load = out_free;
				out_data = '{kept_index: pend_idx_q, kept_valid: 1'b1,
					overflow: ovf_q, last_result: 1'b0};
			end
			S_EMIT_END: begin
				out_load = out_free;
				out_data = '{kept_index: pend_v_q ? pend_idx_q : '0, kept_valid: pend_v_q,
					overflow: ovf_q, last_result: 1'b1};
			end
			default: ;
		endcase
	end

	// Detection store.
	gbs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_BOXES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(stored_q[AW-1:0]),
		.wdata(wr_ent),
		.raddr(raddr),
		.rdata(rd_ent)
	);

	// Overlap pipeline.
	gbs_overlap u_ovl (
		.clk      (clk),
		.arst_n   (arst_n),
		.have_pick(have_pick_q),
		.pick_box (pick_box_q),
		.pick_cls (pick_cls_q),
		.pick_area(pick_area_q),
		.iou_limit(iou_q),
		.in_v     (v_s1),
		.in_idx   (IDX_W'(idx_s1)),
		.in_ent   (rd_ent),
		.busy     (ov_busy),
		.res      (sres)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_q   <= IOU_LIMIT_RST;
			floor_q <= SCORE_FLOOR_RST;
			keep_q  <= KEEP_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_IOU_LIMIT:   iou_q   <= pwdata[15:0];
				REG_SCORE_FLOOR: floor_q <= pwdata[15:0];
				REG_KEEP_LIMIT:  keep_q  <= pwdata[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		pready = 1'b1;
		unique case (paddr[3:2])
			REG_IOU_LIMIT:   prdata = PDATA_W'(iou_q);
			REG_SCORE_FLOOR: prdata = PDATA_W'(floor_q);
			REG_KEEP_LIMIT:  prdata = PDATA_W'(keep_q);
			default:         prdata = '0;
		endcase
	end

	// Control state, set counters, flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stored_q    <= '0;
			load_q      <= '0;
			scan_q      <= '0;
			ovf_q       <= 1'b0;
			have_pick_q <= 1'b0;
			done_q      <= '0;
			best_v_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			emit_cnt_q  <= '0;
			out_v_q     <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_SCAN);

			// Loading.
			if (state_q == S_IDLE && acc) begin
				if (load_q >= CW'(MAX_BOXES)) begin
					ovf_q <= 1'b1;
				end else begin
					load_q <= load_q + CW'(1);
				end
				if (store) begin
					stored_q <= n_next;
				end
				if (det.last_box) begin
					scan_q      <= '0;
					have_pick_q <= 1'b0;
					best_v_q    <= 1'b0;
				end
			end

			// Address sweep.
			if (state_q == S_SCAN) begin
				scan_q <= scan_q + CW'(1);
			end

			// Suppression and best-candidate tracking.
			if (sres.v) begin
				if (sres.sup) begin
					done_q[sres.idx[AW-1:0]] <= 1'b1;
				end else if (!done_q[sres.idx[AW-1:0]] &&
					(!best_v_q || sres.score > best_score_q)) begin
					best_v_q <= 1'b1;
				end
			end

			// Taking a pick.
			if (state_q == S_PICK_CAP) begin
				pend_v_q           <= 1'b1;
				emit_cnt_q         <= emit_cnt_q + KEEP_W'(1);
				done_q[best_idx_q] <= 1'b1;
			end
			if (state_q == S_AREA) begin
				scan_q      <= '0;
				have_pick_q <= 1'b1;
				best_v_q    <= 1'b0;
			end

			// End of set.
			if (state_q == S_EMIT_END && out_free) begin
				stored_q   <= '0;
				load_q     <= '0;
				ovf_q      <= 1'b0;
				done_q     <= '0;
				pend_v_q   <= 1'b0;
				emit_cnt_q <= '0;
			end

			// Output register.
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!res_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[AW-1:0];
		if (sres.v && !sres.sup && !done_q[sres.idx[AW-1:0]] &&
			(!best_v_q || sres.score > best_score_q)) begin
			best_idx_q   <= sres.idx[AW-1:0];
			best_score_q <= sres.score;
		end
		if (state_q == S_PICK_CAP) begin
			pick_box_q <= rd_ent.box;
			pick_cls_q <= rd_ent.cls;
			pick_w_q   <= span(rd_ent.box.left, rd_ent.box.right);
			pick_h_q   <= span(rd_ent.box.top, rd_ent.box.bottom);
			pend_idx_q <= rd_ent.pos;
		end
		if (state_q == S_AREA) begin
			pick_area_q <= pick_w_q * pick_h_q;
		end
		if (out_load) begin
			res_q <= out_data;
		end
	end

	assign res_valid = out_v_q;
	assign res       = res_q;

endmodule

[rtl/gbs_checker.sv]
// Port-level checker of the box suppressor and its bind to the top level.
module gbs_checker
	import gbs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      det_valid,
	input logic      det_stall,
	input det_item_t det,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res
);

	// A stalled result item holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result item changed");

	// An empty result always closes its set.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.kept_valid |-> res.last_result)
		else $error("empty result item is not last");

	// An empty result names no index.
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.kept_valid |-> res.kept_index == '0)
		else $error("empty result item carries an index");

	// The last detection of a set starts processing, which holds off new items.
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		det_valid && !det_stall && det.last_box |=> det_stall)
		else $error("input taken right after the last item of a set");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.det_valid(det_valid),
	.det_stall(det_stall),
	.det      (det),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

[verif/greedy_box_suppression_test.sv]
// Self-checking testbench for the greedy box suppressor, with its own scoreboard.
`timescale 1ns / 1ps

module greedy_box_suppression_test;
	import gbs_pkg::*;

	localparam int CAP        = 64;
	localparam int IDLE_LIMIT = 200000;

	// Predicts the kept indices of each detection set and checks the results.
	class nms_scoreboard;
		box_t              boxes[CAP];
		logic [15:0]       scores[CAP];
		logic [CLS_W-1:0]  classes[CAP];
		logic [IDX_W-1:0]  positions[CAP];
		bit                dropped[CAP];
		int                stored_n;
		int                loaded_n;
		bit                ovf_seen;
		logic [15:0]       iou_lim;
		logic [15:0]       floor_lvl;
		logic [KEEP_W-1:0] keep_max;
		res_item_t         kept_q[$];
		int                errors;

		function new();
			iou_lim = IOU_LIMIT_RST;
			floor_lvl = SCORE_FLOOR_RST;
			keep_max = KEEP_LIMIT_RST;
			errors = 0;
			clear_set();
		endfunction

		function void clear_set();
			foreach (dropped[i]) dropped[i] = 0;
			stored_n = 0;
			loaded_n = 0;
			ovf_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_IOU_LIMIT: iou_lim = v[15:0];
				REG_SCORE_FLOOR: floor_lvl = v[15:0];
				REG_KEEP_LIMIT: keep_max = v[KEEP_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return kept_q.size();
		endfunction

		// Extent of an edge pair; an inverted pair counts as zero.
		function longint unsigned extent(logic [15:0] lo, logic [15:0] hi);
			return (hi > lo) ? longint'(hi - lo) : 0;
		endfunction

		// Division-free overlap test: inter * 2^16 > limit * union.
		function bit too_close(box_t a, box_t b);
			longint unsigned inter, uni, area_a, area_b;
			logic [15:0] l, t, r, d;
			l = (a.left > b.left) ? a.left : b.left;
			t = (a.top > b.top) ? a.top : b.top;
			r = (a.right < b.right) ? a.right : b.right;
			d = (a.bottom < b.bottom) ? a.bottom : b.bottom;
			inter = extent(l, r) * extent(t, d);
			area_a = extent(a.left, a.right) * extent(a.top, a.bottom);
			area_b = extent(b.left, b.right) * extent(b.top, b.bottom);
			uni = area_a + area_b - inter;
			return (inter << 16) > longint'(iou_lim) * uni;
		endfunction

		function void note_detection(det_item_t d);
			int ord[CAP];
			int i, j, cur, lim, cnt, a, b;
			res_item_t r;
			if (loaded_n >= CAP) begin
				ovf_seen = 1;
			end else begin
				if (d.score > floor_lvl && stored_n < CAP) begin
					boxes[stored_n] = '{bottom: d.box_bottom, right: d.box_right,
						top: d.box_top, left: d.box_left};
					scores[stored_n] = d.score;
					classes[stored_n] = d.class_id;
					positions[stored_n] = loaded_n[IDX_W-1:0];
					stored_n++;
				end
				loaded_n++;
			end
			if (!d.last_box) return;

			// Stable descending sort by score.
			for (i = 0; i < stored_n; i++) begin
				cur = i;
				j = i;
				while (j > 0 && scores[ord[j-1]] < scores[cur]) begin
					ord[j] = ord[j-1];
					j--;
				end
				ord[j] = cur;
			end
			lim = (keep_max == 0) ? 1 : int'(keep_max);
			if (lim > CAP) lim = CAP;

			// Greedy pass: each survivor removes later same-class overlaps.
			cnt = 0;
			for (i = 0; i < stored_n; i++) begin
				a = ord[i];
				if (dropped[a]) continue;
				if (cnt < lim) begin
					r = '{kept_index: positions[a], kept_valid: 1'b1,
						overflow: ovf_seen, last_result: 1'b0};
					kept_q.insert(kept_q.size(), r);
					cnt++;
				end
				for (j = i + 1; j < stored_n; j++) begin
					b = ord[j];
					if (dropped[b] || classes[a] != classes[b]) continue;
					if (too_close(boxes[a], boxes[b])) dropped[b] = 1;
				end
			end
			if (cnt == 0) begin
				r = '{kept_index: '0, kept_valid: 1'b0, overflow: ovf_seen,
					last_result: 1'b0};
				kept_q.insert(kept_q.size(), r);
			end
			kept_q[kept_q.size()-1].last_result = 1'b1;
			clear_set();
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (kept_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = kept_q.pop_front();
			if (got.kept_index != want.kept_index || got.kept_valid != want.kept_valid ||
				got.overflow != want.overflow || got.last_result != want.last_result) begin
				$display("%0t: result mismatch expected %p actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               det_valid;
	logic               det_stall;
	det_item_t          det;
	logic               res_valid;
	logic               res_stall;
	res_item_t          res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	nms_scoreboard sb = new();
	int            idle_cycles = 0;
	int            hold_cycles = 0;
	int            burst_left = 0;
	int            items_sent = 0;

	greedy_box_suppression dut (
		.clk(clk), .arst_n(arst_n),
		.det_valid(det_valid), .det_stall(det_stall), .det(det),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock generation.
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Monitor both channels and watch for a stuck block.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((det_valid && !det_stall) || (res_valid && !res_stall) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (det_valid && !det_stall) sb.note_detection(det);
			if (res_valid && !res_stall) sb.check_result(res);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int mode, k;
		res_stall = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			for (k = 0; k < 64; k++) begin
				@(posedge clk);
				if (hold_cycles > 0) begin
					res_stall <= 1;
					hold_cycles--;
				end else begin
					case (mode)
						0: res_stall <= 0;
						1: res_stall <= ($urandom_range(0, 9) < 3);
						2: res_stall <= ($urandom_range(0, 9) < 8);
						default: res_stall <= (k % 5 < 2);
					endcase
				end
			end
		end
	end

	// Register write over the configuration port: setup, then access.
	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.write_reg(idx, v);
	endtask

	// Offer one detection in bursts with random gaps; returns after acceptance.
	task automatic send_det(det_item_t it);
		int gap;
		bit hit;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				det_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		det <= it;
		det_valid <= 1;
		burst_left--;
		items_sent++;
		forever begin
			@(negedge clk);
			hit = !det_stall;
			@(posedge clk);
			if (hit) break;
		end
	endtask

	// Let every expected result arrive and the block settle.
	task automatic wait_idle();
		det_valid <= 0;
		@(posedge clk);
		while (sb.pending() > 0 || det_stall) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic det_item_t make_det(logic [15:0] l, logic [15:0] t, logic [15:0] r,
		logic [15:0] b, logic [15:0] s, logic [6:0] c, logic lb);
		det_item_t d;
		d = '{box_left: l, box_top: t, box_right: r, box_bottom: b, score: s,
			class_id: c, last_box: lb};
		return d;
	endfunction

	// Random detection, mostly near a base box so that overlaps are common.
	function automatic det_item_t rand_det(box_t base, logic [15:0] tie_score);
		det_item_t d;
		if ($urandom_range(0, 3) == 0) begin
			d = make_det(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 7'($urandom_range(0, 127)), 1'b0);
		end else begin
			d.box_left = 16'(base.left + $urandom_range(0, 48));
			d.box_top = 16'(base.top + $urandom_range(0, 48));
			d.box_right = 16'(base.right + $urandom_range(0, 48));
			d.box_bottom = 16'(base.bottom + $urandom_range(0, 48));
			d.class_id = 7'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0: d.score = tie_score;
				1: d.score = 16'($urandom);
				default: d.score = 16'($urandom_range(16000, 65535));
			endcase
			d.last_box = 1'b0;
		end
		return d;
	endfunction

	// Random sets until the item quota is reached, optionally one over capacity.
	task automatic run_sets(int quota, bit with_overflow);
		int n, k, stop_at;
		box_t bases[2];
		det_item_t it;
		logic [15:0] tie;
		stop_at = items_sent + quota;
		while (items_sent < stop_at || with_overflow) begin
			if (with_overflow) n = $urandom_range(65, 70);
			else if ($urandom_range(0, 9) == 0) n = $urandom_range(15, 30);
			else n = $urandom_range(1, 10);
			with_overflow = 0;
			foreach (bases[i]) begin
				bases[i].left = 16'($urandom_range(0, 60000));
				bases[i].top = 16'($urandom_range(0, 60000));
				bases[i].right = 16'(bases[i].left + $urandom_range(16, 4000));
				bases[i].bottom = 16'(bases[i].top + $urandom_range(16, 4000));
			end
			tie = 16'($urandom_range(20000, 65535));
			for (k = 0; k < n; k++) begin
				it = rand_det(bases[$urandom_range(0, 1)], tie);
				it.last_box = (k == n - 1);
				send_det(it);
			end
		end
	endtask

	task automatic configure(logic [15:0] iou, logic [15:0] fl, logic [6:0] keep);
		wait_idle();
		write_reg(REG_IOU_LIMIT, {16'd0, iou});
		write_reg(REG_SCORE_FLOOR, {16'd0, fl});
		write_reg(REG_KEEP_LIMIT, {25'd0, keep});
	endtask

	// Stimulus.
	initial begin
		arst_n = 0;
		det_valid = 0;
		det = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed set at reset settings: full-frame duplicates across classes,
		// inverted boxes with zero union, a score at the floor, a light overlap.
		send_det(make_det(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 1'b0));
		send_det(make_det(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd40000, 7'd127, 1'b0));
		send_det(make_det(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd40000, 7'd0, 1'b0));
		send_det(make_det(16'd100, 16'd100, 16'd50, 16'd50, 16'd30000, 7'd0, 1'b0));
		send_det(make_det(16'd100, 16'd100, 16'd50, 16'd50, 16'd30000, 7'd0, 1'b0));
		send_det(make_det(16'd0, 16'd0, 16'd16, 16'd16, 16'd16384, 7'd5, 1'b0));
		send_det(make_det(16'd0, 16'd0, 16'd16, 16'd16, 16'd16385, 7'd5, 1'b0));
		send_det(make_det(16'd8, 16'd0, 16'd24, 16'd16, 16'd20000, 7'd5, 1'b0));
		send_det(make_det(16'd4, 16'd0, 16'd20, 16'd16, 16'd20000, 7'd5, 1'b1));
		// A set where nothing survives the floor.
		send_det(make_det(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 7'd127, 1'b1));
		// A single all-ones detection.
		send_det(make_det(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 1'b1));
		// Same-class chain: the middle box is removed, the far one survives.
		send_det(make_det(16'd0, 16'd0, 16'd160, 16'd160, 16'd60000, 7'd3, 1'b0));
		send_det(make_det(16'd16, 16'd0, 16'd176, 16'd160, 16'd50000, 7'd3, 1'b0));
		send_det(make_det(16'd150, 16'd0, 16'd310, 16'd160, 16'd40000, 7'd3, 1'b1));

		// Lowest floor and overlap limit, single result per set, with a long output hold-off.
		configure(16'd0, 16'd0, 7'd1);
		@(negedge clk) hold_cycles = 400;
		@(posedge clk);
		run_sets(70, 0);

		// Highest floor and overlap limit: nothing passes the floor.
		configure(16'hFFFF, 16'hFFFF, 7'd64);
		run_sets(30, 0);

		// Keep limit of zero behaves as one.
		configure(16'd32768, 16'd1000, 7'd0);
		run_sets(60, 0);

		// Keep limit beyond capacity, with an oversized set.
		configure(16'd20000, 16'd8000, 7'd127);
		run_sets(100, 1);

		configure(16'($urandom), 16'($urandom_range(0, 30000)), 7'($urandom_range(1, 64)));
		run_sets(70, 0);

		configure(16'd29491, 16'd0, 7'd64);
		run_sets(90, 1);

		wait_idle();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
